// ----- design/brle_pkg.sv -----
// ============================================================================
// Byte run-length encoder package
// Shared types and constants for the lanes, the pair buffer and the top level.
// ============================================================================
`default_nettype none

package brle_pkg;

    // Longest run held in one pair, as length minus one.
    localparam logic [7:0] RUN_MAX = 8'd255;

    // Width of a lane position; an item carries at most eight bytes.
    localparam int POS_W = 3;

    // One (count, value) pair.
    typedef struct packed {
        logic [7:0] cnt;
        logic [7:0] val;
    } pair_t;

    // Position of the latest run start seen so far along the lanes.
    typedef struct packed {
        logic             seen;
        logic [POS_W-1:0] pos;
    } chain_t;

    // What one lane found about its byte.
    typedef struct packed {
        logic  brk;
        logic  start;
        pair_t pair;
    } lane_res_t;

endpackage

`default_nettype wire

// ----- design/brle_lane.sv -----
// ============================================================================
// Byte run-length encoder lane
// Compares one byte with its neighbor and decides whether a run closes here,
// and if so, the pair for the run that closes.
// ============================================================================
`default_nettype none

module brle_lane #(
    parameter int LANE_IDX = 0
) (
    input  wire logic [7:0]         cur_byte,
    input  wire logic [7:0]         prev_byte,
    input  wire logic               lane_valid,
    input  wire logic               run_open,
    input  wire logic [7:0]         held_count,
    input  wire brle_pkg::chain_t   chain_in,
    output brle_pkg::chain_t        chain_out,
    output brle_pkg::lane_res_t     res
);
    import brle_pkg::*;

    logic       first_byte;
    logic       ovf;
    logic [8:0] held_sum;
    logic [3:0] local_len;

    // The held run already holds 256 bytes before this byte, so adding it would overflow the pair.
    assign held_sum   = {1'b0, held_count} + 9'(LANE_IDX);
    assign ovf        = !chain_in.seen && (held_sum == {1'b0, RUN_MAX});
    assign first_byte = (LANE_IDX == 0) && !run_open;

    assign local_len = 4'(LANE_IDX) - {1'b0, chain_in.pos} - 4'd1;

    always_comb
    begin
        res.brk   = lane_valid && !first_byte && ((cur_byte != prev_byte) || ovf);
        res.start = lane_valid && (res.brk || first_byte);
        res.pair.val = prev_byte;
        if (chain_in.seen)
        begin
            res.pair.cnt = {4'd0, local_len};
        end
        else
        begin
            res.pair.cnt = held_sum[7:0];
        end
        if (res.start)
        begin
            chain_out.seen = 1'b1;
            chain_out.pos  = POS_W'(LANE_IDX);
        end
        else
        begin
            chain_out = chain_in;
        end
    end

endmodule

`default_nettype wire

// ----- design/brle_pair_buf.sv -----
// ============================================================================
// Byte run-length encoder pair buffer
// Holds the pairs of one item and hands them out one per transfer, in order.
// ============================================================================
`default_nettype none

module brle_pair_buf #(
    parameter int SLOTS = 9
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire logic [SLOTS-1:0]   load_mask,
    input  wire brle_pkg::pair_t    load_pairs [SLOTS],
    output logic                    free,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              run_length_minus_one,
    output logic [7:0]              run_byte,
    output logic                    last_pair
);
    import brle_pkg::*;

    logic [SLOTS-1:0] mask_reg;
    logic [SLOTS-1:0] mask_next;
    logic [SLOTS-1:0] sel;
    pair_t            pair_reg [SLOTS];
    pair_t            pair_sel;
    logic             xfer;

    // Lowest pending slot goes out first.
    assign sel       = mask_reg & (~mask_reg + SLOTS'(1));
    assign out_valid = (mask_reg != '0);
    assign last_pair = ((mask_reg & ~sel) == '0);
    assign xfer      = out_valid && out_ready;
    assign free      = !out_valid || (xfer && last_pair);

    always_comb
    begin
        pair_sel = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (sel[i])
            begin
                pair_sel = pair_sel | pair_reg[i];
            end
        end
    end

    assign run_length_minus_one = pair_sel.cnt;
    assign run_byte             = pair_sel.val;

    always_comb
    begin
        mask_next = mask_reg;
        if (load)
        begin
            mask_next = load_mask;
        end
        else if (xfer)
        begin
            mask_next = mask_reg & ~sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                pair_reg[i] <= load_pairs[i];
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/byte_run_length_encoder.sv -----
// ============================================================================
// Byte run-length encoder
// Turns a packed byte stream into (run length minus one, byte) pairs.
// ============================================================================
// An input transfer carries up to LANES bytes, byte zero in the low bits, with
// byte_count giving how many are used (counts above LANES are clipped to
// LANES, a count of zero takes no bytes). Each output transfer is one pair: a
// byte value and the length of its run minus one, so a pair covers 1 to 256
// equal bytes; a longer run is split into several pairs. The open run is
// carried across input transfers, and end_of_stream flushes it after the
// item's bytes and clears the held state. last_pair marks the final pair that
// an input transfer produced; a transfer that closes no run produces nothing.
// Operation: an accepted item is registered and compared by LANES parallel
// lanes; its pairs load into a pair buffer once it is free, and the buffer
// drains one pair per cycle while out_ready is high. The next item loads as
// the last pair of the previous one goes out; until then it waits in the item
// register and in_ready is low. An item produces at most LANES + 1 pairs.
// ============================================================================
`default_nettype none

module byte_run_length_encoder #(
    parameter int LANES = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [63:0] data_bytes,
    input  wire logic [3:0]  byte_count,
    input  wire logic        end_of_stream,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       run_length_minus_one,
    output logic [7:0]       run_byte,
    output logic             last_pair
);
    import brle_pkg::*;

    localparam int SLOTS = LANES + 1;

    // Item register between the input port and the lanes.
    logic              item_vld_reg;
    logic              item_vld_next;
    logic [63:0]       data_reg;
    logic [3:0]        nbytes_reg;
    logic              eos_reg;

    // Open run carried from item to item.
    logic [7:0]        held_byte_reg;
    logic [7:0]        held_byte_next;
    logic [7:0]        held_count_reg;
    logic [7:0]        held_count_next;
    logic              run_open_reg;
    logic              run_open_next;

    logic              accept;
    logic              load;
    logic              buf_free;
    logic [SLOTS-1:0]  load_mask;
    pair_t             load_pairs [SLOTS];
    chain_t            chain [LANES+1];
    lane_res_t         lane_res [LANES];
    logic [3:0]        nbytes;
    logic [7:0]        end_byte;
    logic [7:0]        end_count;
    logic              end_open;
    logic [3:0]        tail_len;

    assign accept   = in_valid && in_ready;
    assign load     = item_vld_reg && buf_free;
    assign in_ready = !item_vld_reg || load;

    // Byte counts above the lane count are clipped.
    assign nbytes = (nbytes_reg > 4'(LANES)) ? 4'(LANES) : nbytes_reg;

    always_comb
    begin
        item_vld_next = item_vld_reg;
        if (accept)
        begin
            item_vld_next = 1'b1;
        end
        else if (load)
        begin
            item_vld_next = 1'b0;
        end
    end

    // Each lane checks its byte against the one before it; lane zero checks
    // against the held byte. The chain tells each lane where the latest run
    // started, which fixes the length of the run it closes.
    assign chain[0] = '{seen: 1'b0, pos: '0};

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        logic [7:0] prev_b;
        if (i == 0)
        begin : g_first
            assign prev_b = held_byte_reg;
        end
        else
        begin : g_rest
            assign prev_b = data_reg[8*(i-1) +: 8];
        end

        brle_lane #(
            .LANE_IDX (i)
        ) u_lane (
            .cur_byte   (data_reg[8*i +: 8]),
            .prev_byte  (prev_b),
            .lane_valid (4'(i) < nbytes),
            .run_open   (run_open_reg),
            .held_count (held_count_reg),
            .chain_in   (chain[i]),
            .chain_out  (chain[i+1]),
            .res        (lane_res[i])
        );
    end

    // The run left open after the item's bytes.
    assign tail_len = nbytes - 4'd1 - {1'b0, chain[LANES].pos};

    always_comb
    begin
        end_byte = held_byte_reg;
        for (int i = 0; i < LANES; i++)
        begin
            if (4'(i + 1) == nbytes)
            begin
                end_byte = data_reg[8*i +: 8];
            end
        end
        if (nbytes == 4'd0)
        begin
            end_count = held_count_reg;
        end
        else if (chain[LANES].seen)
        begin
            end_count = {4'd0, tail_len};
        end
        else
        begin
            end_count = held_count_reg + {4'd0, nbytes};
        end
        end_open = run_open_reg || (nbytes != 4'd0);
    end

    // Merge: one buffer slot per lane in byte order, then the flush slot.
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            load_mask[i]  = lane_res[i].brk;
            load_pairs[i] = lane_res[i].pair;
        end
        load_mask[LANES]      = eos_reg && end_open;
        load_pairs[LANES].cnt = end_count;
        load_pairs[LANES].val = end_byte;
    end

    always_comb
    begin
        held_byte_next  = held_byte_reg;
        held_count_next = held_count_reg;
        run_open_next   = run_open_reg;
        if (load)
        begin
            if (eos_reg)
            begin
                held_byte_next  = '0;
                held_count_next = '0;
                run_open_next   = 1'b0;
            end
            else
            begin
                held_byte_next  = end_byte;
                held_count_next = end_count;
                run_open_next   = end_open;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg   <= 1'b0;
            held_byte_reg  <= '0;
            held_count_reg <= '0;
            run_open_reg   <= 1'b0;
        end
        else
        begin
            item_vld_reg   <= item_vld_next;
            held_byte_reg  <= held_byte_next;
            held_count_reg <= held_count_next;
            run_open_reg   <= run_open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg   <= data_bytes;
            nbytes_reg <= byte_count;
            eos_reg    <= end_of_stream;
        end
    end

    brle_pair_buf #(
        .SLOTS (SLOTS)
    ) u_pair_buf (
        .clk                  (clk),
        .rst_n                (rst_n),
        .load                 (load),
        .load_mask            (load_mask),
        .load_pairs           (load_pairs),
        .free                 (buf_free),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .run_length_minus_one (run_length_minus_one),
        .run_byte             (run_byte),
        .last_pair            (last_pair)
    );

    // With no run open, no count may be left behind.
    a_closed_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !run_open_reg |-> (held_count_reg == 8'd0))
        else $error("held count nonzero with no open run");

    // A waiting item must not be overrun while the buffer is still busy.
    a_hold_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item_vld_reg && !buf_free) |-> !in_ready)
        else $error("input taken while previous item is still waiting");

    // After the last pair of an item goes out, pairs only follow from a new load.
    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_pair) |=> (!out_valid || $past(load)))
        else $error("pairs left over after the last pair of an item");

endmodule

`default_nettype wire

// ----- test/byte_run_length_encoder_test.sv -----
// ============================================================================
// Byte run-length encoder testbench
// Drives packed byte items into the encoder and checks every (count, byte)
// pair that comes out against a predictor of the run logic, with random
// stalls on both sides, a directed table first and random streams after it.
// ============================================================================

module byte_run_length_encoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    import brle_pkg::*;

    localparam int LANES         = 8;
    // Cycles to let pass once nothing is expected; well above the pipeline depth.
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 480;
    localparam int REPORT_LIMIT  = 10;

    // One expected or observed output transfer.
    typedef struct packed {
        pair_t pair;
        logic  last;
    } run_pair_t;

    // How a directed row gets its expected pairs: from the predictor, or typed in.
    typedef enum logic [1:0] {
        FROM_MODEL,
        NO_PAIR,
        ONE_PAIR
    } row_kind_e;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  count;
        logic        eos;
        row_kind_e   kind;
        run_pair_t   pair;
    } stim_row_t;

    // Clock, reset and the block's inputs, all known from time zero.
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic [63:0] data_bytes    = '0;
    logic [3:0]  byte_count    = '0;
    logic        end_of_stream = 1'b0;
    logic        out_ready     = 1'b0;

    logic        in_ready;
    logic        out_valid;
    logic [7:0]  run_length_minus_one;
    logic [7:0]  run_byte;
    logic        last_pair;

    // Predictor state: the open run carried across items.
    logic [7:0]  cur_byte;
    logic [7:0]  cur_len_m1;
    logic        cur_open;
    run_pair_t   item_pairs [LANES+1];

    // Pairs still owed by the block, and pairs seen on the output but not yet
    // compared. Comparison runs on the falling edge so that the order of the
    // processes woken by the rising edge does not matter.
    run_pair_t   pending_pairs [$];
    run_pair_t   seen_pairs [$];

    stim_row_t   stim_rows [$];
    logic [7:0]  stream_q [$];

    int          mismatch_count = 0;
    int          random_items   = 0;
    // When set, neither side stalls; used for whole streams at a time.
    bit          no_stalls      = 1'b0;

    always #6 clk = ~clk;

    byte_run_length_encoder #(
        .LANES(LANES)
    ) i_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .data_bytes          (data_bytes),
        .byte_count          (byte_count),
        .end_of_stream       (end_of_stream),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .run_length_minus_one(run_length_minus_one),
        .run_byte            (run_byte),
        .last_pair           (last_pair)
    );

    // Works out the pairs that one accepted item causes and advances the
    // predictor state. Bytes are taken from the low end; a count above LANES
    // is clipped. A run closes on a different byte or on its 257th byte.
    function automatic int encode_item(input logic [63:0] d, input logic [3:0] c,
                                       input logic e);
        int         taken;
        int         k;
        logic [7:0] b;
        k     = 0;
        taken = (c > LANES) ? LANES : int'(c);
        for (int i = 0; i < taken; i++)
        begin
            b = d[8*i +: 8];
            if (!cur_open)
            begin
                cur_byte   = b;
                cur_len_m1 = 8'd0;
                cur_open   = 1'b1;
            end
            else if (b == cur_byte && cur_len_m1 < RUN_MAX)
            begin
                cur_len_m1 = cur_len_m1 + 8'd1;
            end
            else
            begin
                item_pairs[k] = {cur_len_m1, cur_byte, 1'b0};
                k++;
                cur_byte   = b;
                cur_len_m1 = 8'd0;
            end
        end
        // A flush emits the open run, if any, and clears everything.
        if (e)
        begin
            if (cur_open)
            begin
                item_pairs[k] = {cur_len_m1, cur_byte, 1'b0};
                k++;
            end
            cur_byte   = 8'd0;
            cur_len_m1 = 8'd0;
            cur_open   = 1'b0;
        end
        if (k > 0)
            item_pairs[k-1].last = 1'b1;
        return k;
    endfunction

    // Offers one item after a random gap and returns in the time step of its
    // transfer. valid is only lowered when a gap follows, so it is never
    // dropped and raised in one step. When push_predicted is clear the caller
    // supplies the expected pairs itself.
    task automatic send_item(input logic [63:0] d, input logic [3:0] c, input logic e,
                             input bit push_predicted);
        int gap;
        int n;
        gap = no_stalls ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_bytes    <= d;
        byte_count    <= c;
        end_of_stream <= e;
        do @(posedge clk); while (!in_ready);
        n = encode_item(d, c, e);
        if (push_predicted)
            for (int i = 0; i < n; i++)
                pending_pairs.push_back(item_pairs[i]);
    endtask

    // Holds the sender off until every owed pair has come out, then gives the
    // block time to finish an item that causes no pair.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (pending_pairs.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Packs the queued stream bytes into items of random size and sends them.
    // Most streams close with the flag on their last data item, some with a
    // separate empty flush item, and a few not at all so that the open run
    // carries into whatever comes next.
    task automatic send_stream_bytes();
        int          close_sel;
        int          cnt;
        int          take;
        int          sel;
        logic [63:0] d;
        logic        closing;
        close_sel = $urandom_range(0, 9);
        while (stream_q.size() > 0)
        begin
            sel = $urandom_range(0, 19);
            if (sel == 0)
                cnt = 0;
            else if (sel == 1)
                cnt = $urandom_range(9, 15);
            else
                cnt = $urandom_range(1, 8);
            take = (cnt > LANES) ? LANES : cnt;
            if (take > stream_q.size())
            begin
                take = stream_q.size();
                cnt  = take;
            end
            // Bytes above the count are junk that the block must ignore.
            d = {$urandom, $urandom};
            for (int i = 0; i < take; i++)
                d[8*i +: 8] = stream_q.pop_front();
            closing = (stream_q.size() == 0) && (close_sel <= 6);
            send_item(d, 4'(cnt), closing, 1'b1);
            random_items++;
        end
        if (close_sel == 7 || close_sel == 8)
        begin
            send_item({$urandom, $urandom}, 4'd0, 1'b1, 1'b1);
            random_items++;
        end
    endtask

    // Appends a run of len copies of value to the byte stream.
    task automatic queue_run(input logic [7:0] value, input int len);
        for (int i = 0; i < len; i++)
            stream_q.push_back(value);
    endtask

    // Output side: capture every pair transfer at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            seen_pairs.push_back({run_length_minus_one, run_byte, last_pair});
    end

    // Compare captured pairs with the oldest expectation, field by field.
    always @(negedge clk)
    begin
        run_pair_t got;
        run_pair_t want;
        while (seen_pairs.size() > 0)
        begin
            got = seen_pairs.pop_front();
            if (pending_pairs.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected pair: len-1=%0d byte=%02h last=%0b",
                             got.pair.cnt, got.pair.val, got.last);
            end
            else
            begin
                want = pending_pairs.pop_front();
                if (got.pair.cnt !== want.pair.cnt || got.pair.val !== want.pair.val ||
                    got.last !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("pair mismatch: expected len-1=%0d byte=%02h last=%0b, %s",
                                 want.pair.cnt, want.pair.val, want.last,
                                 $sformatf("got len-1=%0d byte=%02h last=%0b",
                                           got.pair.cnt, got.pair.val, got.last));
                end
            end
        end
    end

    // Receiver: for every transfer, draw a random stall. ready is
    // only lowered when a stall follows.
    initial
    begin
        int w;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            w = no_stalls ? 0 : $urandom_range(0, 4);
            if (w > 0)
            begin
                out_ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // Stimulus and the final verdict.
    initial
    begin
        int         mode;
        int         runs;
        int         len;
        logic [7:0] value;

        cur_byte   = 8'd0;
        cur_len_m1 = 8'd0;
        cur_open   = 1'b0;

        // Directed table. Rows whose pairs are obvious carry them typed in;
        // the rest are left to the predictor.
        // Empty flush straight after reset: nothing is open, so no pair.
        stim_rows.push_back('{64'h0, 4'd0, 1'b1, NO_PAIR, 17'h0});
        // Empty item without the flag does nothing at all.
        stim_rows.push_back('{64'h0, 4'd0, 1'b0, NO_PAIR, 17'h0});
        // Eight ones bytes flushed at once.
        stim_rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, ONE_PAIR,
                              {8'd7, 8'hFF, 1'b1}});
        // Eight zero bytes stay open, then an empty flush with junk data emits them.
        stim_rows.push_back('{64'h0, 4'd8, 1'b0, NO_PAIR, 17'h0});
        stim_rows.push_back('{64'hDEAD_BEEF_0123_4567, 4'd0, 1'b1, ONE_PAIR,
                              {8'd7, 8'h00, 1'b1}});
        // Count of fifteen clips to eight lanes; all bytes differ.
        stim_rows.push_back('{64'h0706_0504_0302_0100, 4'd15, 1'b0, FROM_MODEL, 17'h0});
        stim_rows.push_back('{64'hFFFF_FFFF_FFFF_FF07, 4'd1, 1'b1, ONE_PAIR,
                              {8'd1, 8'h07, 1'b1}});
        stim_rows.push_back('{64'h5555_5555_5555_5555, 4'd9, 1'b1, ONE_PAIR,
                              {8'd7, 8'h55, 1'b1}});
        stim_rows.push_back('{64'hAA55_AA55_AA55_AA55, 4'd8, 1'b1, FROM_MODEL, 17'h0});
        // An open run followed by eight new bytes and a flush: the most pairs
        // that one item can cause.
        stim_rows.push_back('{64'hFFFF_FFFF_FFFF_FF11, 4'd1, 1'b0, FROM_MODEL, 17'h0});
        stim_rows.push_back('{64'h0102_0304_0506_0708, 4'd8, 1'b1, FROM_MODEL, 17'h0});
        // A run carried across two items, then an empty flush.
        stim_rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0, NO_PAIR, 17'h0});
        stim_rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0, NO_PAIR, 17'h0});
        stim_rows.push_back('{64'h0, 4'd0, 1'b1, ONE_PAIR, {8'd15, 8'hFF, 1'b1}});
        stim_rows.push_back('{64'h8000_0000_0000_0001, 4'd8, 1'b1, FROM_MODEL, 17'h0});
        stim_rows.push_back('{64'hFFFF_FFFF_FF12_3456, 4'd3, 1'b0, FROM_MODEL, 17'h0});
        stim_rows.push_back('{64'h0000_0012_1212_1212, 4'd5, 1'b0, FROM_MODEL, 17'h0});
        stim_rows.push_back('{64'hFFFF_FFFF_FFFF_3412, 4'd2, 1'b1, FROM_MODEL, 17'h0});
        // Seven bytes taken, the top byte ignored.
        stim_rows.push_back('{64'h00FF_FFFF_FFFF_FFFF, 4'd7, 1'b1, ONE_PAIR,
                              {8'd6, 8'hFF, 1'b1}});
        stim_rows.push_back('{64'h0, 4'd8, 1'b1, ONE_PAIR, {8'd7, 8'h00, 1'b1}});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (stim_rows[r])
        begin
            send_item(stim_rows[r].data, stim_rows[r].count, stim_rows[r].eos,
                      stim_rows[r].kind == FROM_MODEL);
            if (stim_rows[r].kind == ONE_PAIR)
                pending_pairs.push_back(stim_rows[r].pair);
        end

        // The sender waits for the block to empty at least once here.
        wait_for_drain();

        // Random part: mostly well-formed streams, some long runs that cross
        // the 256-byte split, and some noise items with every field random.
        while (random_items < RANDOM_ITEMS)
        begin
            no_stalls = ($urandom_range(0, 4) == 0);
            mode      = $urandom_range(0, 19);
            if (mode < 3)
            begin
                value = 8'($urandom);
                case ($urandom_range(0, 7))
                    0: len = 255;
                    1: len = 256;
                    2: len = 257;
                    3: len = 258;
                    4: len = 511;
                    5: len = 512;
                    6: len = 513;
                    default: len = $urandom_range(1, 300);
                endcase
                queue_run(value, len);
                runs = $urandom_range(0, 3);
                for (int i = 0; i < runs; i++)
                    queue_run(8'($urandom), $urandom_range(1, 4));
                send_stream_bytes();
            end
            else if (mode < 16)
            begin
                runs = $urandom_range(1, 12);
                for (int i = 0; i < runs; i++)
                begin
                    case ($urandom_range(0, 3))
                        0: value = 8'h00;
                        1: value = 8'hFF;
                        default: value = 8'($urandom);
                    endcase
                    len = $urandom_range(0, 19);
                    if (len < 14)
                        len = $urandom_range(1, 4);
                    else if (len < 19)
                        len = $urandom_range(5, 20);
                    else
                        len = $urandom_range(21, 60);
                    queue_run(value, len);
                end
                send_stream_bytes();
            end
            else
            begin
                runs = $urandom_range(1, 6);
                for (int i = 0; i < runs; i++)
                begin
                    send_item({$urandom, $urandom}, 4'($urandom_range(0, 15)),
                              $urandom_range(0, 3) == 0, 1'b1);
                    random_items++;
                end
            end
            if ($urandom_range(0, 9) == 0)
                wait_for_drain();
        end

        // All stimulus is in; let the block empty and settle, then judge.
        in_valid <= 1'b0;
        no_stalls = 1'b0;
        while (pending_pairs.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        @(posedge clk);
        if (mismatch_count == 0 && pending_pairs.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
